// ===== hw/rtl/sidta_pkg.sv =====
package sidta_pkg;

  // Field widths and conversion sizes.
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

  // ASCII codes, reduced to the output width.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text.
//
// Input channel (in_valid, in_ready, in_value): one two's complement integer
// per transfer. in_ready is high only while the sequencer is idle.
// Output channel (out_valid, out_ready, out_char_code, out_last): one ASCII
// character per transfer, most significant first, '-' ahead of a negative
// number; out_last marks the final digit. No leading zeros; zero gives "0".
//
// Timing: after an input transfer the magnitude goes through shift-add-3
// binary-to-BCD conversion, one bit per cycle in a single shared correction
// unit. Leading zero digits are then dropped at one per cycle (up to 9), the
// sign or first digit is picked, and the sign and digits are loaded into the
// output register at one per cycle while the receiver keeps up. Dropped and
// emitted digits always add up to ten. The sequencer takes no new input until
// the final character sits in the output register, and a new input is taken
// as soon as it does.
//
// A stalled receiver simply holds the output register; the sequencer waits.
// Reset returns the sequencer to idle and empties the output register.
module signed_int_to_decimal_ascii
  import sidta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHAR_W-1:0]        out_char_code,
  output logic                     out_last
);

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [VALUE_W-1:0]  in_bits;
  logic [VALUE_W-1:0]  mag;
  logic [BCD_W-1:0]    bcd_adj;
  logic [3:0]          top_digit;
  logic                slot_free;

  // Magnitude as an unsigned word, so the most negative value is exact.
  assign in_bits = VALUE_W'(in_value);
  assign mag     = in_bits[VALUE_W-1] ? (VALUE_W'(0) - in_bits) : in_bits;

  // Shared correction unit: add 3 to every BCD digit of 5 or more.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign slot_free = !out_valid_r || out_ready;

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    dig_nxt       = dig_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bin_nxt   = mag;
          bcd_nxt   = '0;
          step_nxt  = '0;
          dig_nxt   = DIG_W'(NUM_DIGITS);
          neg_nxt   = in_bits[VALUE_W-1];
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(VALUE_W - 1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zeros, but always keep the units digit.
        if (top_digit == 4'd0 && dig_r > DIG_W'(1)) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt = dig_r - DIG_W'(1);
        end else if (neg_r) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
          out_last_nxt  = (dig_r == DIG_W'(1));
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          dig_nxt       = dig_r - DIG_W'(1);
          if (dig_r == DIG_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; datapath registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    step_r     <= step_nxt;
    dig_r      <= dig_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // Every character shown is a minus sign or a decimal digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS) ||
                  ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + CHAR_W'(9))))
    else $error("output character out of range");

  // A minus sign is never the final character.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

  // The remaining digit count stays in range while digits are emitted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (dig_r >= DIG_W'(1)) && (dig_r <= DIG_W'(NUM_DIGITS)))
    else $error("digit count out of range");

  // An accepted input always starts the conversion pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CONV) && (step_r == STEP_W'(0)))
    else $error("conversion did not start after input transfer");

endmodule
